// ===== hdl/psv_pkg.sv =====
// Shared constants and result codes for the prime sieve.
`default_nettype none
package psv_pkg;

  localparam int CellsDefault     = 16;
  localparam int ValueBitsDefault = 16;

  localparam int CandW    = 16;
  localparam int VerdictW = 2;
  localparam int SlotW    = 4;

  localparam int unsigned MinCandidate = 2;

  localparam logic [VerdictW-1:0] VERDICT_NEW       = 2'd0;
  localparam logic [VerdictW-1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_FINAL     = 2'd2;
  localparam logic [VerdictW-1:0] VERDICT_IGNORED   = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/pipelined_prime_sieve.sv =====
// Prime sieve top level: cell sequencer, prime store and output register.
//
// Input channel: in_valid_i / in_stall_o carry one candidate per item; feed
// 2, 3, 4, ... in rising order. Output channel: out_valid_o / out_stall_i
// carry one result per item (verdict, slot, echoed value).
// Items are taken one at a time; in_stall_o is high while an item is in work.
// A candidate below two, or any item after the final prime, goes straight to
// the output stage. Otherwise the candidate visits the filled cells in order,
// and each visited cell reads its prime from the store, then runs the
// bit-serial remainder unit, one bit per cycle.
// The result sits in an output register, so the next item is taken while
// an earlier result still waits; a held result stalls the next result and the input.
// Reset empties all cells and clears the done state; no clearing pass.
`default_nettype none
module pipelined_prime_sieve #(
  parameter int CELLS      = psv_pkg::CellsDefault,
  parameter int VALUE_BITS = psv_pkg::ValueBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [psv_pkg::CandW-1:0]     in_candidate_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [psv_pkg::VerdictW-1:0]  out_verdict_o,
  output      logic [psv_pkg::SlotW-1:0]     out_slot_o,
  output      logic [psv_pkg::CandW-1:0]     out_value_o
);

  localparam int CandBits = (VALUE_BITS < psv_pkg::CandW) ? VALUE_BITS : psv_pkg::CandW;
  localparam int AddrW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CntW     = $clog2(CELLS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [CntW-1:0]                fill_q, fill_d;
  logic [CntW-1:0]                idx_q, idx_d;
  logic                           done_q, done_d;
  logic [CandBits-1:0]            cand_q, cand_d;
  logic [psv_pkg::VerdictW-1:0]   res_verdict_q, res_verdict_d;
  logic [psv_pkg::SlotW-1:0]      res_slot_q, res_slot_d;
  logic                           out_valid_q, out_valid_d;
  logic [psv_pkg::VerdictW-1:0]   out_verdict_q, out_verdict_d;
  logic [psv_pkg::SlotW-1:0]      out_slot_q, out_slot_d;
  logic [psv_pkg::CandW-1:0]      out_value_q, out_value_d;

  logic [CandBits-1:0]            in_cand;
  logic                           ram_we;
  logic [CandBits-1:0]            prime_rd;
  logic                           mod_start;
  logic                           mod_done;
  logic [CandBits-1:0]            mod_rem;

  assign in_cand = CandBits'(in_candidate_i);

  psv_ram #(
    .WIDTH (CandBits),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (prime_rd)
  );

  psv_mod #(
    .W (CandBits)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cand_q),
    .divisor_i  (prime_rd),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    idx_d         = idx_q;
    done_d        = done_q;
    cand_d        = cand_q;
    res_verdict_d = res_verdict_q;
    res_slot_d    = res_slot_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    out_slot_d    = out_slot_q;
    out_value_d   = out_value_q;
    ram_we        = 1'b0;
    mod_start     = 1'b0;

    // drop the held result once it is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cand_d = in_cand;
          idx_d  = '0;
          if (done_q || in_cand < CandBits'(psv_pkg::MinCandidate)) begin
            res_verdict_d = psv_pkg::VERDICT_IGNORED;
            res_slot_d    = '0;
            state_d       = S_EMIT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (idx_q == fill_q) begin
          if (fill_q == CntW'(CELLS)) begin
            done_d        = 1'b1;
            res_verdict_d = psv_pkg::VERDICT_FINAL;
            res_slot_d    = '0;
          end else begin
            // first empty cell: store the candidate there
            ram_we        = 1'b1;
            fill_d        = fill_q + 1'b1;
            res_verdict_d = psv_pkg::VERDICT_NEW;
            res_slot_d    = psv_pkg::SlotW'(idx_q);
          end
          state_d = S_EMIT;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        mod_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (mod_done) begin
          // a zero prime would leave the nonzero candidate as remainder
          if (mod_rem == '0) begin
            res_verdict_d = psv_pkg::VERDICT_COMPOSITE;
            res_slot_d    = psv_pkg::SlotW'(idx_q);
            state_d       = S_EMIT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_verdict_d = res_verdict_q;
          out_slot_d    = res_slot_q;
          out_value_d   = psv_pkg::CandW'(cand_q);
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q        <= cand_d;
    res_verdict_q <= res_verdict_d;
    res_slot_q    <= res_slot_d;
    out_verdict_q <= out_verdict_d;
    out_slot_q    <= out_slot_d;
    out_value_q   <= out_value_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_verdict_o = out_verdict_q;
  assign out_slot_o    = out_slot_q;
  assign out_value_o   = out_value_q;

endmodule
`default_nettype wire

// ===== hdl/psv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/psv_mod.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module psv_mod #(
  parameter int W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output      logic         done_o,
  output      logic [W-1:0] rem_o
);

  localparam int CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    dsr_q, dsr_d;
  logic [W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = W'(trial);
      end
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for pipelined_prime_sieve: random-stall driver, monitor and predictor.
module tb_top;

  localparam int NumCells  = psv_pkg::CellsDefault;
  localparam int RandItems = 1600;
  localparam int CycleCap  = 3_000_000;
  localparam int DrainWait = 400;
  localparam int HoldLen   = 800;
  localparam int HoldAt    = 150;

  typedef logic [psv_pkg::CandW-1:0] cand_t;

  typedef struct packed {
    logic                                    done;
    logic [NumCells-1:0]                     filled;
    logic [NumCells-1:0][psv_pkg::CandW-1:0] primes;
  } sieve_state_t;

  typedef struct packed {
    logic [psv_pkg::VerdictW-1:0] verdict;
    logic [psv_pkg::SlotW-1:0]    slot;
    cand_t                        value;
  } sieve_result_t;

  typedef struct packed {
    sieve_state_t  st;
    sieve_result_t res;
  } sieve_step_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  cand_t                        in_candidate_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [psv_pkg::VerdictW-1:0] out_verdict_o;
  logic [psv_pkg::SlotW-1:0]    out_slot_o;
  cand_t                        out_value_o;

  cand_t         cand_queue[$];
  sieve_result_t owed_results[$];
  sieve_state_t  model_state = '0;
  sieve_state_t  plan_state = '0;

  int accepted_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_cnt = 0;
  int verdict_tally[4] = '{0, 0, 0, 0};
  logic calm;

  pipelined_prime_sieve u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_candidate_i (in_candidate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_verdict_o  (out_verdict_o),
    .out_slot_o     (out_slot_o),
    .out_value_o    (out_value_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // One candidate through the chain: first empty cell stores it, first dividing cell stops it.
  function automatic sieve_step_t sieve_advance(sieve_state_t s, cand_t cand);
    sieve_step_t r;
    logic        hit;
    r.st = s;
    r.res.value = cand;
    r.res.slot = '0;
    r.res.verdict = psv_pkg::VERDICT_IGNORED;
    hit = 1'b0;
    if (!s.done && cand >= psv_pkg::MinCandidate) begin
      for (int i = 0; i < NumCells; i++) begin
        if (!hit) begin
          if (!s.filled[i]) begin
            r.st.primes[i] = cand;
            r.st.filled[i] = 1'b1;
            r.res.verdict = psv_pkg::VERDICT_NEW;
            r.res.slot = psv_pkg::SlotW'(i);
            hit = 1'b1;
          end else if (s.primes[i] != '0 && cand % s.primes[i] == '0) begin
            r.res.verdict = psv_pkg::VERDICT_COMPOSITE;
            r.res.slot = psv_pkg::SlotW'(i);
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        r.st.done = 1'b1;
        r.res.verdict = psv_pkg::VERDICT_FINAL;
      end
    end
    return r;
  endfunction

  // Track the chain as the stimulus will leave it, so later items can be shaped.
  task automatic queue_candidate(input cand_t c);
    sieve_step_t t;
    t = sieve_advance(plan_state, c);
    plan_state = t.st;
    cand_queue.push_back(c);
  endtask

  assign calm = (accepted_cnt >= 400) && (accepted_cnt < 700);

  // Driver: offer the next item once the current one is taken; predict on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    sieve_step_t step;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_candidate_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        step = sieve_advance(model_state, in_candidate_i);
        model_state = step.st;
        owed_results.push_back(step.res);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cand_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          in_valid_i <= 1'b1;
          in_candidate_i <= cand_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt == HoldAt) begin
      hold_left <= HoldLen;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each taken result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    sieve_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_cnt <= checked_cnt + 1;
        verdict_tally[out_verdict_o] <= verdict_tally[out_verdict_o] + 1;
        if (owed_results.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected result: verdict %0d slot %0d value %0d",
                     out_verdict_o, out_slot_o, out_value_o);
        end else begin
          want = owed_results.pop_front();
          if (out_verdict_o !== want.verdict || out_slot_o !== want.slot ||
              out_value_o !== want.value) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: expected verdict %0d slot %0d value %0d, got %0d %0d %0d",
                       want.verdict, want.slot, want.value,
                       out_verdict_o, out_slot_o, out_value_o);
          end
        end
      end
      out_stall_i <= (hold_left > 1) || (!calm && $urandom_range(0, 99) < 30);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleCap) begin
      $display("pipelined_prime_sieve verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    sieve_step_t trial;
    cand_t       c;
    int          counted;
    int          pick;
    int          nfill;
    int          p;
    bit          allow;

    // Directed: extremes, ignored values, stores, composites, out-of-order store.
    queue_candidate(16'd0);
    queue_candidate(16'd1);
    queue_candidate(16'd2);
    queue_candidate(16'd3);
    queue_candidate(16'd4);
    queue_candidate(16'd2);
    queue_candidate(16'd9);
    queue_candidate(16'hFFFF);
    queue_candidate(16'hFFFE);
    queue_candidate(16'h8000);
    queue_candidate(16'd25);
    queue_candidate(16'd5);
    queue_candidate(16'd125);
    queue_candidate(16'd15);
    queue_candidate(16'd35);
    queue_candidate(16'd7);
    queue_candidate(16'd49);
    queue_candidate(16'd1);
    queue_candidate(16'hAAAA);
    queue_candidate(16'h5555);

    // Random: mostly multiples of stored values, new stores throttled to fill the chain late.
    counted = 0;
    while (counted < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_candidate(cand_t'($urandom_range(0, 1)));
        continue;
      end
      nfill = $countones(plan_state.filled);
      allow = (nfill < 5 + (11 * counted) / 1500);
      if (pick < 25 || (allow && pick < 35)) begin
        c = cand_t'($urandom_range(0, 16'hFFFF));
      end else begin
        p = int'(plan_state.primes[$urandom_range(0, nfill - 1)]);
        c = cand_t'(p * $urandom_range(1, 65535 / p));
      end
      trial = sieve_advance(plan_state, c);
      if (trial.res.verdict == psv_pkg::VERDICT_COMPOSITE ||
          (trial.res.verdict == psv_pkg::VERDICT_NEW && allow)) begin
        queue_candidate(c);
        counted++;
      end
    end

    // Fill what is left, reach the final prime, then probe the done state.
    while (!plan_state.done) begin
      c = cand_t'($urandom_range(2, 16'hFFFF));
      trial = sieve_advance(plan_state, c);
      if (trial.res.verdict != psv_pkg::VERDICT_COMPOSITE)
        queue_candidate(c);
    end
    queue_candidate(16'd0);
    queue_candidate(16'd2);
    queue_candidate(16'hFFFF);
    repeat (12) queue_candidate(cand_t'($urandom_range(0, 16'hFFFF)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cand_queue.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d items sent, %0d results checked: %0d stored, %0d composite,",
             accepted_cnt, checked_cnt, verdict_tally[psv_pkg::VERDICT_NEW],
             verdict_tally[psv_pkg::VERDICT_COMPOSITE]);
    $display("%0d final, %0d ignored; chain cells filled: %0d, done reached: %0b, mismatches: %0d",
             verdict_tally[psv_pkg::VERDICT_FINAL], verdict_tally[psv_pkg::VERDICT_IGNORED],
             $countones(model_state.filled), model_state.done, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("pipelined_prime_sieve verification clean");
    end else begin
      $display("pipelined_prime_sieve verification failed");
    end
    $finish;
  end

endmodule

// ===== pipelined_prime_sieve.f =====
hdl/psv_pkg.sv
hdl/psv_ram.sv
hdl/psv_mod.sv
hdl/pipelined_prime_sieve.sv
bench/tb_top.sv
